/* sv/suis_pkg.sv */
// shared types, codes and constants of the sorted identifier set
`default_nettype none

package suis_pkg;

  // default store depth
  localparam int CAPACITY_DEF = 64;

  // identifier width
  localparam int ID_W = 32;

  // fan-in of one node of the result reduction tree
  localparam int RED_RADIX = 4;

  // transaction kinds on the input channel
  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_QUERY   = 2'd1,
    MODE_READ    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_END     = 2'd3
  } status_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic ins_en;  // apply the insert shift this cycle
    logic rd;      // report the entry under the cursor instead of a match
  } cell_ctrl_t;

  // number of collapse steps to bring n leaves down to one
  function automatic int red_levels(input int n);
    int lv;
    int w;
    lv = 0;
    w  = n;
    while (w > 1) begin
      w  = (w + RED_RADIX - 1) / RED_RADIX;
      lv = lv + 1;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

/* sv/sorted_unique_id_set.sv */
// top level: chain of sorted storage cells, result reduction and sequencer
//
//  channel | ports  | direction | tdata            | tuser (low bit up)
//  --------+--------+-----------+------------------+---------------------------
//  input   | in_*   | slave     | ident [31:0]     | mode [1:0]
//  result  | out_*  | master    | read_value [31:0]| status [1:0], found [2]
//
//  every transaction passes from accept to result through one load of the
//  reduction tree, one fold per tree level (radix 4) and one apply step; the
//  tree depth sets how long a transaction takes.
//  one transaction is in flight at a time; in_tready is high only when idle.
//  a finished result waits in the output register; the next input is taken
//  meanwhile, and its own result waits until that register is free.
//  rst_n (synchronous, active low) empties the set and rewinds the cursor.
`default_nettype none

module sorted_unique_id_set #(
  parameter int CAPACITY = suis_pkg::CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // ident[31:0]
  input  wire  [1:0]  in_tuser,   // mode[1:0]
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // read_value[31:0]
  output logic [2:0]  out_tuser   // status[1:0], found[2]
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = suis_pkg::red_levels(CAPACITY);
  localparam int LW     = $clog2(LEVELS + 1);
  localparam int IW     = suis_pkg::ID_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REDUCE = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [LW-1:0]        lvl_r, lvl_nxt;
  suis_pkg::mode_t      mode_r;
  logic [IW-1:0]        ident_r;
  logic [CW-1:0]        entry_cnt_r, entry_cnt_nxt;
  logic [CW-1:0]        rd_cursor_r, rd_cursor_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [IW-1:0]        out_value_r, out_value_nxt;
  suis_pkg::status_t    out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt;

  logic                 in_acc;
  logic                 slot_free;
  logic                 finish;
  logic                 full;
  suis_pkg::cell_ctrl_t ctrl;

  logic [IW-1:0]        cell_data [CAPACITY];
  logic [CAPACITY-1:0]  cell_gt;
  logic [CAPACITY-1:0]  cell_valid;
  logic [CAPACITY-1:0]  cell_hit;
  logic [IW-1:0]        cell_val [CAPACITY];

  logic                 red_load;
  logic                 red_step;
  logic                 red_hit;
  logic [IW-1:0]        red_val;

  // handshake
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign finish    = (state_r == S_FINISH) && slot_free;
  assign full      = (entry_cnt_r == CW'(CAPACITY));

  // broadcast control to the chain
  assign ctrl.rd     = (mode_r == suis_pkg::MODE_READ);
  assign ctrl.ins_en = finish && (mode_r == suis_pkg::MODE_INSERT) && !red_hit && !full;

  // the chain of cells
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [IW-1:0] l_data;
    logic          l_gt;
    logic          l_valid;

    if (gi == 0) begin : g_first
      assign l_data  = '0;
      assign l_gt    = 1'b0;
      assign l_valid = 1'b1;
    end else begin : g_rest
      assign l_data  = cell_data[gi-1];
      assign l_gt    = cell_gt[gi-1];
      assign l_valid = cell_valid[gi-1];
    end

    suis_cell #(
      .INDEX (gi),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .ident      (ident_r),
      .cursor     (rd_cursor_r),
      .left_data  (l_data),
      .left_gt    (l_gt),
      .left_valid (l_valid),
      .data       (cell_data[gi]),
      .gt         (cell_gt[gi]),
      .valid      (cell_valid[gi]),
      .hit        (cell_hit[gi]),
      .val        (cell_val[gi])
    );
  end

  // fold the per-cell answers down to one
  assign red_load = (state_r == S_REDUCE) && (lvl_r == '0);
  assign red_step = (state_r == S_REDUCE) && (lvl_r != '0);

  suis_reduce #(
    .N (CAPACITY)
  ) u_reduce (
    .clk     (clk),
    .load    (red_load),
    .step    (red_step),
    .hit_in  (cell_hit),
    .val_in  (cell_val),
    .hit_out (red_hit),
    .val_out (red_val)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_REDUCE;
          lvl_nxt   = '0;
        end
      end
      S_REDUCE: begin
        if (lvl_r == LW'(LEVELS)) begin
          state_nxt = S_FINISH;
        end else begin
          lvl_nxt = lvl_r + LW'(1);
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // count, cursor and result for the finishing transaction
  always_comb begin
    entry_cnt_nxt  = entry_cnt_r;
    rd_cursor_nxt  = rd_cursor_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    if (finish) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = '0;
      out_status_nxt = suis_pkg::ST_OK;
      out_found_nxt  = 1'b0;
      case (mode_r)
        suis_pkg::MODE_INSERT: begin
          if (red_hit) begin
            out_status_nxt = suis_pkg::ST_PRESENT;
          end else if (full) begin
            out_status_nxt = suis_pkg::ST_FULL;
          end else begin
            entry_cnt_nxt = entry_cnt_r + CW'(1);
          end
        end
        suis_pkg::MODE_QUERY: begin
          out_found_nxt = red_hit;
        end
        suis_pkg::MODE_READ: begin
          if (red_hit) begin
            out_value_nxt = red_val;
            rd_cursor_nxt = rd_cursor_r + CW'(1);
          end else begin
            out_status_nxt = suis_pkg::ST_END;
          end
        end
        suis_pkg::MODE_RESTART: begin
          rd_cursor_nxt = '0;
        end
        default: begin
          out_status_nxt = suis_pkg::ST_OK;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      entry_cnt_r <= '0;
      rd_cursor_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      rd_cursor_r <= rd_cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= suis_pkg::mode_t'(in_tuser);
      ident_r <= in_tdata;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_found_r, out_status_r};

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cursor_r <= entry_cnt_r)
    else $error("read cursor beyond entry count");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(entry_cnt_r))
    else $error("occupied cells disagree with entry count");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == suis_pkg::ST_END)) |-> (out_value_r == '0))
    else $error("end of list with nonzero value");

endmodule

`default_nettype wire

/* sv/suis_cell.sv */
// one storage cell of the sorted chain: holds an entry, compares, shifts up on insert
`default_nettype none

module suis_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 7
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  suis_pkg::cell_ctrl_t        ctrl,
  input  wire  [suis_pkg::ID_W-1:0]   ident,
  input  wire  [CW-1:0]               cursor,
  // left neighbor
  input  wire  [suis_pkg::ID_W-1:0]   left_data,
  input  wire                         left_gt,
  input  wire                         left_valid,
  // own state toward the right neighbor
  output logic [suis_pkg::ID_W-1:0]   data,
  output logic                        gt,
  output logic                        valid,
  // contribution to the result reduction
  output logic                        hit,
  output logic [suis_pkg::ID_W-1:0]   val
);

  logic [suis_pkg::ID_W-1:0] data_r, data_nxt;
  logic                      valid_r, valid_nxt;
  logic                      eq;
  logic                      sel;

  // local compares against the broadcast identifier
  assign gt  = valid_r && (data_r > ident);
  assign eq  = valid_r && (data_r == ident);
  assign sel = valid_r && (cursor == CW'(INDEX));

  // match for insert and query, cursor entry for read
  always_comb begin
    if (ctrl.rd) begin
      hit = sel;
      val = sel ? data_r : '0;
    end else begin
      hit = eq;
      val = '0;
    end
  end

  // insert: entries above the key move up one cell, the key lands in the gap
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.ins_en) begin
      if (left_gt) begin
        data_nxt  = left_data;
        valid_nxt = 1'b1;
      end else if (gt || (left_valid && !valid_r)) begin
        data_nxt  = ident;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

/* sv/suis_reduce.sv */
// registered radix tree that folds the per-cell hit flags and values into one
`default_nettype none

module suis_reduce #(
  parameter int N = suis_pkg::CAPACITY_DEF
) (
  input  wire                         clk,
  input  wire                         load,
  input  wire                         step,
  input  wire  [N-1:0]                hit_in,
  input  wire  [suis_pkg::ID_W-1:0]   val_in [N],
  output logic                        hit_out,
  output logic [suis_pkg::ID_W-1:0]   val_out
);

  localparam int R = suis_pkg::RED_RADIX;

  logic [N-1:0]              hit_r;
  logic [suis_pkg::ID_W-1:0] val_r [N];
  logic [N-1:0]              hit_step;
  logic [suis_pkg::ID_W-1:0] val_step [N];

  // each node folds R neighbors into its own slot
  for (genvar gi = 0; gi < N; gi++) begin : g_node
    logic [R-1:0]              h_term;
    logic [suis_pkg::ID_W-1:0] v_term [R];

    for (genvar gk = 0; gk < R; gk++) begin : g_term
      if (gi * R + gk < N) begin : g_on
        assign h_term[gk] = hit_r[gi * R + gk];
        assign v_term[gk] = val_r[gi * R + gk];
      end else begin : g_off
        assign h_term[gk] = 1'b0;
        assign v_term[gk] = '0;
      end
    end

    always_comb begin
      val_step[gi] = '0;
      for (int k = 0; k < R; k++) begin
        val_step[gi] = val_step[gi] | v_term[k];
      end
    end

    assign hit_step[gi] = |h_term;
  end

  // load from the cells, then collapse one level per step
  always_ff @(posedge clk) begin
    if (load) begin
      hit_r <= hit_in;
      val_r <= val_in;
    end else if (step) begin
      hit_r <= hit_step;
      val_r <= val_step;
    end
  end

  assign hit_out = hit_r[0];
  assign val_out = val_r[0];

endmodule

`default_nettype wire
